// ===== src/quoted_printable_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// quoted-printable decoder assertion macros
// shared concurrent check forms for the decoder core
// ----------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_DECODER_CORE_DEFINES_SVH
`define QUOTED_PRINTABLE_DECODER_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define QPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qpd check failed: same-cycle rule");

// next-cycle implication, off while in reset
`define QPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qpd check failed: next-cycle rule");

`endif

// ===== src/qpd_pkg.sv =====
// ----------------------------------------------------------------------------
// qpd_pkg
// types and constants shared by the quoted-printable decoder modules
// ----------------------------------------------------------------------------
package qpd_pkg;

  // characters with a meaning in the encoding
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_Q  = 8'h3F;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // most bytes one transaction can produce
  localparam int unsigned RunMax = 3;
  localparam int unsigned RunCntW = $clog2(RunMax + 1);
  localparam int unsigned RunPosW = $clog2(RunMax);

  // queue between front and back, depth a power of two
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  // decoder state carried from byte to byte
  typedef struct packed {
    logic       eq;    // '=' waiting
    logic       dig;   // one hex digit after the '='
    logic [7:0] dch;   // that digit character
    logic       cr;    // CR waiting for a possible LF
  } qpd_state_t;

  // bytes produced by one input transaction
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [RunCntW-1:0]     cnt;
  } qpd_run_t;

  // queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } qpd_q_status_t;

endpackage

// ===== src/qpd_fifo.sv =====
// ----------------------------------------------------------------------------
// qpd_fifo
// short flop queue of decoded runs between the front and back parts
// ----------------------------------------------------------------------------
module qpd_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  qpd_pkg::qpd_run_t      push_run,
  input  logic                   pop,
  output qpd_pkg::qpd_run_t      head_run,
  output qpd_pkg::qpd_q_status_t status
);

  qpd_pkg::qpd_run_t                 mem_r [qpd_pkg::QDepth];
  logic [qpd_pkg::QPtrW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [qpd_pkg::QPtrW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [qpd_pkg::QCntW-1:0]         cnt_r, cnt_nxt;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == qpd_pkg::QCntW'(qpd_pkg::QDepth));
  assign head_run     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// ===== src/qpd_front.sv =====
// ----------------------------------------------------------------------------
// qpd_front
// accepts raw bytes, tracks escape and line-end state, queues decoded runs
// ----------------------------------------------------------------------------
module qpd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  input  logic                   in_end_of_data,
  input  qpd_pkg::qpd_q_status_t q_status,
  output logic                   q_push,
  output qpd_pkg::qpd_run_t      q_run
);

  typedef struct packed {
    qpd_pkg::qpd_state_t st;
    qpd_pkg::qpd_run_t   run;
  } qpd_work_t;

  qpd_pkg::qpd_state_t st_r, st_nxt;
  qpd_work_t           work;
  logic                accept;

  // {valid, value} of a hex digit, either case
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic qpd_work_t put_byte(input qpd_work_t s, input logic [7:0] b);
    qpd_work_t r;
    r = s;
    if (r.run.cnt != qpd_pkg::RunCntW'(qpd_pkg::RunMax)) begin
      r.run.bytes[r.run.cnt[qpd_pkg::RunPosW-1:0]] = b;
      r.run.cnt = r.run.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic qpd_work_t plain_byte(input qpd_work_t s, input logic [7:0] b);
    qpd_work_t r;
    r = s;
    priority if (b == qpd_pkg::CH_EQ) begin
      r.st.eq = 1'b1;
    end else if (b == qpd_pkg::CH_CR) begin
      r.st.cr = 1'b1;
    end else if (b == qpd_pkg::CH_LF) begin
      r = put_byte(r, qpd_pkg::CH_LF);
    end else begin
      r = put_byte(r, (b == 8'h00) ? qpd_pkg::CH_Q : b);
    end
    return r;
  endfunction

  function automatic qpd_work_t take_byte(input qpd_work_t s, input logic [7:0] b);
    qpd_work_t  r;
    logic [4:0] hi;
    logic [4:0] lo;
    r  = s;
    hi = hex_val(s.st.dch);
    lo = hex_val(b);
    priority if (s.st.cr) begin
      if (b == qpd_pkg::CH_LF) begin
        // hard line end, or soft break when '=' precedes
        if (!s.st.eq) begin
          r = put_byte(r, qpd_pkg::CH_LF);
        end
        r.st = '0;
      end else begin
        if (s.st.eq) begin
          r = put_byte(r, qpd_pkg::CH_EQ);
        end
        r = put_byte(r, qpd_pkg::CH_CR);
        r.st = '0;
        r = plain_byte(r, b);
      end
    end else if (s.st.eq && s.st.dig) begin
      if (hi[4] && lo[4]) begin
        r = put_byte(r, {hi[3:0], lo[3:0]});
        r.st = '0;
      end else begin
        r = put_byte(r, qpd_pkg::CH_EQ);
        r = put_byte(r, s.st.dch);
        r.st = '0;
        r = plain_byte(r, b);
      end
    end else if (s.st.eq) begin
      priority if (lo[4]) begin
        r.st.dig = 1'b1;
        r.st.dch = b;
      end else if (b == qpd_pkg::CH_LF) begin
        r.st = '0;
      end else if (b == qpd_pkg::CH_CR) begin
        r.st.cr = 1'b1;
      end else begin
        r = put_byte(r, qpd_pkg::CH_EQ);
        r.st = '0;
        r = plain_byte(r, b);
      end
    end else begin
      r.st = '0;
      r = plain_byte(r, b);
    end
    return r;
  endfunction

  always_comb begin
    work.st  = st_r;
    work.run = '0;
    work     = take_byte(work, in_byte);
    if (in_end_of_data) begin
      // flush a half escape, drop a lone '=' or CR
      if (work.st.eq && work.st.dig && !work.st.cr) begin
        work = put_byte(work, qpd_pkg::CH_EQ);
        work = put_byte(work, work.st.dch);
      end
      work.st = '0;
    end
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && (work.run.cnt != '0);
  assign q_run    = work.run;
  assign st_nxt   = accept ? work.st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== src/qpd_back.sv =====
// ----------------------------------------------------------------------------
// qpd_back
// takes queued runs and hands out their bytes one per transaction
// ----------------------------------------------------------------------------
module qpd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qpd_pkg::qpd_q_status_t q_status,
  input  qpd_pkg::qpd_run_t      q_run,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last_of_run
);

  logic                         cur_vld_r, cur_vld_nxt;
  qpd_pkg::qpd_run_t            cur_run_r, cur_run_nxt;
  logic [qpd_pkg::RunPosW-1:0]  pos_r, pos_nxt;
  logic                         at_last;
  logic                         out_acc;
  logic                         load;

  assign at_last = (qpd_pkg::RunCntW'(pos_r) + 1'b1) == cur_run_r.cnt;
  assign out_acc = cur_vld_r && !out_stall;
  assign load    = !cur_vld_r || (out_acc && at_last);
  assign q_pop   = load && !q_status.empty;

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    cur_run_nxt = cur_run_r;
    pos_nxt     = pos_r;
    if (load) begin
      cur_vld_nxt = !q_status.empty;
      if (q_pop) begin
        cur_run_nxt = q_run;
        pos_nxt     = '0;
      end
    end else if (out_acc) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      pos_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_run_r <= cur_run_nxt;
  end

  assign out_valid       = cur_vld_r;
  assign out_byte        = cur_run_r.bytes[pos_r];
  assign out_last_of_run = at_last;

endmodule

// ===== src/quoted_printable_decoder_core.sv =====
// ----------------------------------------------------------------------------
// quoted_printable_decoder_core
// quoted-printable byte stream decoder with a decoupled front and back
// ----------------------------------------------------------------------------
// usage:
//   in_* channel takes one encoded byte per transaction; in_end_of_data marks
//   the final byte and flushes any held '=' / digit / CR state
//   out_* channel gives decoded bytes one per transaction; out_last_of_run is
//   high on the last byte caused by one input transaction
//   an input byte that causes no output (held '=', digit or CR) gives nothing
// timing:
//   input bytes pass through the run queue and then the back part's run register
//   input side takes one byte per cycle while the 4-entry run queue has room
//   output side gives one byte per cycle while out_stall is low; an input producing
//   n bytes, 1 to 3, gives n output transactions
// reset:
//   synchronous active-low rst_n empties the queue and clears decoder state
// stalls:
//   out_stall holds the current byte; the queue fills and then in_stall rises
// ----------------------------------------------------------------------------
`include "quoted_printable_decoder_core_defines.svh"

module quoted_printable_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  // queue wiring between the two halves
  qpd_pkg::qpd_q_status_t q_status;
  qpd_pkg::qpd_run_t      q_push_run;
  qpd_pkg::qpd_run_t      q_head_run;
  logic                   q_push;
  logic                   q_pop;

  // front: classify each byte, update escape state, queue nonempty runs
  qpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_data (in_end_of_data),
    .q_status       (q_status),
    .q_push         (q_push),
    .q_run          (q_push_run)
  );

  // run queue, lets either side stall on its own
  qpd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_run (q_push_run),
    .pop      (q_pop),
    .head_run (q_head_run),
    .status   (q_status)
  );

  // back: serialize each run onto the output channel
  qpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .q_run           (q_head_run),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // checks
  // front never writes a full queue
  `QPD_ASSERT_NOW(a_no_push_full, clk, rst_n, q_push, !q_status.full)
  // back never reads an empty queue
  `QPD_ASSERT_NOW(a_no_pop_empty, clk, rst_n, q_pop, !q_status.empty)
  // only runs that carry bytes get queued
  `QPD_ASSERT_NOW(a_push_nonempty, clk, rst_n, q_push, q_push_run.cnt != '0)
  // an idle back picks up waiting work in the next cycle
  `QPD_ASSERT_NEXT(a_back_loads, clk, rst_n, !out_valid && !q_status.empty, out_valid)

endmodule

// ===== test/tb_quoted_printable_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_quoted_printable_decoder_core
// self-checking bench: a directed table of escapes, line breaks and flush
// cases, then random encoded text under several idle and stall patterns,
// every decoded byte compared in order against the table or a behavioral decoder
// ----------------------------------------------------------------------------
module tb_quoted_printable_decoder_core;

  // extra cycles waited after every expected result has been seen
  localparam int DRAIN_GAP = 8;
  // cycles with no transaction on either side before giving up
  localparam int WATCHDOG_LIMIT = 1000;
  // length of the forced receiver hold-off
  localparam int HOLD_CYCLES = 60;

  // one decoded byte waiting to be seen on the output channel
  typedef struct {
    logic [7:0] val;
    logic       last_flag;
  } decoded_byte_t;

  // one row of the directed table; res is used only when typed is set
  typedef struct {
    logic [7:0]      in_b;
    bit              eod;
    bit              typed;
    int              n;
    logic [2:0][7:0] res;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  // behavioral decoder state and the bytes of the current input
  qpd_pkg::qpd_state_t dec_st;
  logic [7:0]          run_out[$];
  decoded_byte_t       expected_out[$];
  stim_row_t           directed_rows[$];

  int errors;
  int items_sent;
  int bytes_checked;
  int quiet_cycles;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  bit hold_done;

  quoted_printable_decoder_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_data (in_end_of_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // hex digit value, -1 for anything that is not 0-9, A-F or a-f
  function automatic int hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  // at most three bytes come out of one input transaction
  function automatic void emit(logic [7:0] b);
    if (run_out.size() < qpd_pkg::RunMax) run_out.push_back(b);
  endfunction

  // a byte seen with nothing held: '=' and CR are held, NUL is replaced
  function automatic void take_plain(logic [7:0] b);
    if (b == qpd_pkg::CH_EQ) dec_st.eq = 1'b1;
    else if (b == qpd_pkg::CH_CR) dec_st.cr = 1'b1;
    else if (b == qpd_pkg::CH_LF) emit(qpd_pkg::CH_LF);
    else emit(b == 8'h00 ? qpd_pkg::CH_Q : b);
  endfunction

  // advance the decoder by one encoded byte, leaving its output in run_out
  function automatic void decode_byte(logic [7:0] b, bit eod);
    int hi;
    int lo;
    run_out.delete();
    if (dec_st.cr) begin
      // CR LF is a hard break, or a soft one when an '=' came first
      if (b == qpd_pkg::CH_LF) begin
        if (!dec_st.eq) emit(qpd_pkg::CH_LF);
        dec_st = '0;
      end else begin
        if (dec_st.eq) emit(qpd_pkg::CH_EQ);
        emit(qpd_pkg::CH_CR);
        dec_st = '0;
        take_plain(b);
      end
    end else if (dec_st.eq && dec_st.dig) begin
      hi = hex_value(dec_st.dch);
      lo = hex_value(b);
      if (hi >= 0 && lo >= 0) begin
        emit(8'(hi * 16 + lo));
        dec_st = '0;
      end else begin
        // broken escape goes out literally
        emit(qpd_pkg::CH_EQ);
        emit(dec_st.dch);
        dec_st = '0;
        take_plain(b);
      end
    end else if (dec_st.eq) begin
      if (hex_value(b) >= 0) begin
        dec_st.dig = 1'b1;
        dec_st.dch = b;
      end else if (b == qpd_pkg::CH_LF) begin
        dec_st = '0;
      end else if (b == qpd_pkg::CH_CR) begin
        dec_st.cr = 1'b1;
      end else begin
        emit(qpd_pkg::CH_EQ);
        dec_st = '0;
        take_plain(b);
      end
    end else begin
      dec_st = '0;
      take_plain(b);
    end
    // end of data: a half escape is flushed, everything else dropped
    if (eod) begin
      if (dec_st.eq && dec_st.dig && !dec_st.cr) begin
        emit(qpd_pkg::CH_EQ);
        emit(dec_st.dch);
      end
      dec_st = '0;
    end
  endfunction

  function automatic void add_row(logic [7:0] b, bit eod, bit typed, int n,
                                  logic [7:0] r0 = 8'h00, logic [7:0] r1 = 8'h00,
                                  logic [7:0] r2 = 8'h00);
    stim_row_t row;
    row.in_b  = b;
    row.eod   = eod;
    row.typed = typed;
    row.n     = n;
    row.res   = {r2, r1, r0};
    directed_rows.push_back(row);
  endfunction

  // offer one input transaction, with random idle cycles before it, and
  // record what it should produce once it is accepted
  task automatic send_item(logic [7:0] b, bit eod, bit typed = 1'b0, int n = 0,
                           logic [2:0][7:0] res = '0);
    int k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_data <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    decode_byte(b, eod);
    // typed rows carry their own expectation, the rest use the decoder
    if (typed) begin
      for (k = 0; k < n; k++) expected_out.push_back('{res[k], k == n - 1});
    end else begin
      for (k = 0; k < run_out.size(); k++)
        expected_out.push_back('{run_out[k], k == run_out.size() - 1});
    end
  endtask

  // a random hex digit, letters in either case
  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  // mostly well-formed text: escapes, soft and hard breaks, plain text,
  // with some broken escapes, lone CRs, NULs and raw noise mixed in
  task automatic send_random_run(int count);
    logic [7:0] seq[$];
    int         sent;
    int         kind;
    int         i;
    bit         close_data;
    sent = 0;
    while (sent < count) begin
      seq.delete();
      kind = $urandom_range(99);
      if (kind < 30) begin
        seq.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end else if (kind < 55) begin
        seq.push_back(qpd_pkg::CH_EQ);
        seq.push_back(pick_hex());
        seq.push_back(pick_hex());
      end else if (kind < 63) begin
        seq.push_back(qpd_pkg::CH_EQ);
        if ($urandom_range(1)) seq.push_back(qpd_pkg::CH_CR);
        seq.push_back(qpd_pkg::CH_LF);
      end else if (kind < 73) begin
        if ($urandom_range(1)) seq.push_back(qpd_pkg::CH_CR);
        seq.push_back(qpd_pkg::CH_LF);
      end else if (kind < 81) begin
        seq.push_back(qpd_pkg::CH_EQ);
        if ($urandom_range(1)) seq.push_back(pick_hex());
        seq.push_back(8'($urandom_range(255)));
      end else if (kind < 86) begin
        seq.push_back(qpd_pkg::CH_CR);
        seq.push_back(8'($urandom_range(255)));
      end else if (kind < 89) begin
        seq.push_back(8'h00);
      end else begin
        seq.push_back(8'($urandom_range(255)));
      end
      // now and then close the data on the last byte of a sequence,
      // sometimes in the middle of a half-finished escape
      close_data = ($urandom_range(9) == 0);
      if (close_data && $urandom_range(2) == 0 && seq.size() > 1) seq.pop_back();
      for (i = 0; i < seq.size(); i++) begin
        send_item(seq[i], close_data && (i == seq.size() - 1));
        sent++;
      end
    end
  endtask

  // stop offering and let every pending result come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // receiver: random stall, or a long hold-off while hold_req is raised
  initial begin : receiver
    int held_cycles;
    held_cycles = 0;
    hold_done   = 1'b0;
    out_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        held_cycles++;
        if (held_cycles == HOLD_CYCLES) begin
          hold_done   = 1'b1;
          held_cycles = 0;
        end
      end else begin
        if (!hold_req) hold_done = 1'b0;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // output checker and watchdog
  always @(posedge clk) begin
    decoded_byte_t exp_b;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        bytes_checked++;
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected output transaction byte=%02h last=%0b",
                   $time, out_byte, out_last_of_run);
          errors++;
        end else begin
          exp_b = expected_out.pop_front();
          if (out_byte !== exp_b.val) begin
            $display("%0t: out_byte mismatch expected=%02h actual=%02h",
                     $time, exp_b.val, out_byte);
            errors++;
          end
          if (out_last_of_run !== exp_b.last_flag) begin
            $display("%0t: out_last_of_run mismatch expected=%0b actual=%0b",
                     $time, exp_b.last_flag, out_last_of_run);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_out.size());
        $display("** quoted_printable_decoder_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : main
    errors         = 0;
    items_sent     = 0;
    bytes_checked  = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    dec_st         = '0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_data = 1'b0;

    // directed table: byte, end of data, typed, count, bytes
    add_row(8'h41, 0, 1, 1, 8'h41);                 // plain 'A'
    add_row(8'h00, 0, 1, 1, qpd_pkg::CH_Q);         // raw NUL becomes '?'
    add_row(8'hFF, 0, 1, 1, 8'hFF);                 // top byte passes
    add_row(qpd_pkg::CH_EQ, 0, 1, 0);               // "=00" decodes to zero
    add_row(8'h30, 0, 1, 0);
    add_row(8'h30, 0, 1, 1, 8'h00);
    add_row(qpd_pkg::CH_EQ, 0, 0, 0);               // "=eF" mixed case
    add_row(8'h65, 0, 0, 0);
    add_row(8'h46, 0, 0, 0);
    add_row(qpd_pkg::CH_EQ, 0, 1, 0);               // half escape at line end
    add_row(8'h34, 0, 1, 0);
    add_row(qpd_pkg::CH_LF, 0, 1, 3, qpd_pkg::CH_EQ, 8'h34, qpd_pkg::CH_LF);
    add_row(qpd_pkg::CH_EQ, 0, 1, 0);               // soft break
    add_row(qpd_pkg::CH_LF, 0, 1, 0);
    add_row(qpd_pkg::CH_CR, 0, 1, 0);               // lone CR
    add_row(8'h42, 0, 1, 2, qpd_pkg::CH_CR, 8'h42);
    add_row(qpd_pkg::CH_EQ, 0, 0, 0);               // escape split by a CR
    add_row(qpd_pkg::CH_CR, 0, 0, 0);
    add_row(8'h43, 0, 0, 0);
    add_row(qpd_pkg::CH_EQ, 0, 1, 0);               // end of data, "=a" held
    add_row(8'h61, 1, 1, 2, qpd_pkg::CH_EQ, 8'h61);
    add_row(qpd_pkg::CH_EQ, 1, 1, 0);               // end of data, '=' held
    add_row(qpd_pkg::CH_CR, 1, 1, 0);               // end of data, CR held
    add_row(qpd_pkg::CH_CR, 0, 1, 0);               // hard break CR LF
    add_row(qpd_pkg::CH_LF, 0, 1, 1, qpd_pkg::CH_LF);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].in_b, directed_rows[i].eod, directed_rows[i].typed,
                directed_rows[i].n, directed_rows[i].res);
    drain_results();

    // random text under each idle pattern: none, sender, receiver, both
    send_idle_pct = 0;  stall_pct = 0;
    send_random_run(28);
    drain_results();
    send_idle_pct = 50; stall_pct = 0;
    send_random_run(28);
    drain_results();
    send_idle_pct = 0;  stall_pct = 50;
    send_random_run(28);
    drain_results();
    send_idle_pct = 35; stall_pct = 35;
    send_random_run(28);
    drain_results();

    // receiver holds off while the sender keeps offering, so the run
    // queue can fill and raise in_stall
    send_idle_pct = 0;  stall_pct = 0;
    hold_req = 1'b1;
    send_random_run(20);
    in_valid <= 1'b0;
    wait (hold_done);
    hold_req = 1'b0;
    drain_results();

    $display("run covered %0d input transactions (%0d from the directed table)",
             items_sent, directed_rows.size());
    $display("and %0d decoded bytes across idle, stall and hold-off phases",
             bytes_checked);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("** quoted_printable_decoder_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, expected_out.size());
      $display("** quoted_printable_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
